>>> rtl/core/fgjh_pkg.sv
package fgjh_pkg;

    localparam int TS_W        = 40;
    localparam int PERIOD_W    = 30;
    localparam int LIMITS_W    = 64;
    localparam int LIMIT_W     = 8;
    localparam int LIMIT_NUM   = 8;
    localparam int LIMIT_IDX_W = 3;
    localparam int BIN_IDX_W   = 4;
    localparam int BIN_CNT_W   = 32;
    localparam int CFG_IDX_W   = 4;

    // gaps at or above 2^GAP_NARROW_W ms exceed every limit times any period
    localparam int GAP_NARROW_W = 19;
    localparam int NS_PER_MS_W  = 20;
    localparam int SCALED_W     = GAP_NARROW_W + NS_PER_MS_W;
    localparam int RHS_W        = LIMIT_W + PERIOD_W;

    localparam logic [NS_PER_MS_W-1:0] NS_PER_MS = NS_PER_MS_W'(1000000);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16666667);
    localparam logic [LIMITS_W-1:0] LIMITS_RESET = 64'hB478_3C30_2414_0F06;

    localparam logic [CFG_IDX_W-1:0] REG_VSYNC_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMITS   = CFG_IDX_W'(1);

    localparam logic ACT_FRAME  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic            action;
        logic [TS_W-1:0] timestamp_ms;
        logic            scrolling;
    } t_in_item;

    typedef struct packed {
        logic [TS_W-1:0]      session_start_out;
        logic [TS_W-1:0]      session_length_ms;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [BIN_CNT_W-1:0] bin_count;
        logic                 last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAME,
        S_SCALE,
        S_THR,
        S_MUL,
        S_CMP,
        S_INC,
        S_REPORT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic open_session;
        logic set_prev;
        logic take_gap;
        logic scale;
        logic k_clr;
        logic mul;
        logic k_inc;
        logic bin_hit;
        logic bin_last;
        logic inc_bin;
        logic close_session;
        logic start_report;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_action;
        logic scrolling;
        logic open;
        logic backward;
        logic below_thr;
        logic hit;
        logic k_last;
        logic pending;
        logic out_free;
        logic idx_last;
    } t_status;

endpackage

>>> rtl/core/fgjh_ctrl.sv
module fgjh_ctrl
    import fgjh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.in_action == ACT_REPORT) ? S_REPORT : S_FRAME;
                end
            end
            S_FRAME: begin
                if (i_sts.scrolling && i_sts.open && !i_sts.backward) begin
                    n_state = S_SCALE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCALE: n_state = S_THR;
            S_THR:   n_state = i_sts.below_thr ? S_IDLE : S_MUL;
            S_MUL:   n_state = S_CMP;
            S_CMP: begin
                if (i_sts.hit || i_sts.k_last) begin
                    n_state = S_INC;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_INC:    n_state = S_IDLE;
            S_REPORT: n_state = i_sts.pending ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (i_sts.out_free && i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: o_cmd.load_in = i_in_valid;
            S_FRAME: begin
                if (i_sts.scrolling) begin
                    if (!i_sts.open) begin
                        o_cmd.open_session = 1'b1;
                    end else if (i_sts.backward) begin
                        o_cmd.set_prev = 1'b1;
                    end else begin
                        o_cmd.take_gap = 1'b1;
                    end
                end
            end
            S_SCALE: o_cmd.scale = 1'b1;
            S_THR:   o_cmd.k_clr = !i_sts.below_thr;
            S_MUL:   o_cmd.mul = 1'b1;
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.bin_hit = 1'b1;
                end else if (i_sts.k_last) begin
                    o_cmd.bin_last = 1'b1;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_INC: o_cmd.inc_bin = 1'b1;
            S_REPORT: begin
                if (i_sts.pending) begin
                    o_cmd.start_report = 1'b1;
                end else begin
                    o_cmd.close_session = 1'b1;
                end
            end
            S_EMIT:  o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_last_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.out_free && i_sts.idx_last) |=> (r_state == S_IDLE))
        else $error("report did not finish after its last item");

    a_inc_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INC) |-> ($past(r_state) == S_CMP))
        else $error("bin increment without a bin search");

    a_frame_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME || r_state == S_REPORT) |-> ($past(o_cmd.load_in)))
        else $error("item handled without being taken");

endmodule

>>> rtl/core/fgjh_dp.sv
module fgjh_dp
    import fgjh_pkg::*;
#(
    parameter int BIN_COUNT   = 9,
    parameter int COUNT_WIDTH = 32
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_sts,
    input  t_in_item             i_in_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMITS_W-1:0]  i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    localparam int IDX_W = $clog2(BIN_COUNT);
    localparam int NLIM  = (BIN_COUNT - 1 > LIMIT_NUM) ? LIMIT_NUM : BIN_COUNT - 1;
    localparam logic [IDX_W-1:0]       LAST_BIN = IDX_W'(BIN_COUNT - 1);
    localparam logic [LIMIT_IDX_W-1:0] K_LAST   = LIMIT_IDX_W'(NLIM - 1);

    logic [PERIOD_W-1:0]    r_period;
    logic [LIMITS_W-1:0]    r_limits;
    t_in_item               r_in;
    logic                   r_open;
    logic [TS_W-1:0]        r_start;
    logic [TS_W-1:0]        r_prev;
    logic                   r_pending;
    logic [COUNT_WIDTH-1:0] r_counts [BIN_COUNT];
    logic [TS_W-1:0]        r_gap;
    logic                   r_big;
    logic [SCALED_W-1:0]    r_scaled;
    logic [RHS_W-1:0]       r_rhs;
    logic [LIMIT_IDX_W-1:0] r_k;
    logic [IDX_W-1:0]       r_bin;
    logic [IDX_W-1:0]       r_idx;
    logic [TS_W-1:0]        r_length;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [LIMIT_W-1:0]     cur_limit;
    logic [SCALED_W-1:0]    thr;
    logic                   out_free;

    assign rd_addr   = i_cmd.emit ? r_idx : r_bin;
    assign rd_count  = r_counts[rd_addr];
    assign cur_limit = r_limits[{r_k, 3'b000} +: LIMIT_W];
    assign thr       = SCALED_W'({r_period, 1'b0});
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts           = '0;
        o_sts.in_action = i_in_item.action;
        o_sts.scrolling = r_in.scrolling;
        o_sts.open      = r_open;
        o_sts.backward  = (r_in.timestamp_ms < r_prev);
        o_sts.below_thr = !r_big && (r_scaled <= thr);
        o_sts.hit       = !r_big && (r_scaled < SCALED_W'(r_rhs));
        o_sts.k_last    = (r_k == K_LAST);
        o_sts.pending   = r_pending;
        o_sts.out_free  = out_free;
        o_sts.idx_last  = (r_idx == LAST_BIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_limits <= LIMITS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_VSYNC_PERIOD) begin
                r_period <= i_cfg_data[PERIOD_W-1:0];
            end else if (i_cfg_index == REG_BIN_LIMITS) begin
                r_limits <= i_cfg_data;
            end
        end
    end

    // session state and histogram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_start   <= '0;
            r_prev    <= '0;
            r_pending <= 1'b0;
            for (int i = 0; i < BIN_COUNT; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            if (i_cmd.open_session) begin
                r_open  <= 1'b1;
                r_start <= r_in.timestamp_ms;
                r_prev  <= r_in.timestamp_ms;
            end
            if (i_cmd.set_prev || i_cmd.take_gap) begin
                r_prev <= r_in.timestamp_ms;
            end
            if (i_cmd.inc_bin) begin
                r_pending <= 1'b1;
                if (rd_count != '1) begin
                    r_counts[r_bin] <= rd_count + COUNT_WIDTH'(1);
                end
            end
            if (i_cmd.close_session) begin
                r_open  <= 1'b0;
                r_start <= '0;
            end
            if (i_cmd.emit && r_idx == LAST_BIN) begin
                r_open    <= 1'b0;
                r_start   <= '0;
                r_pending <= 1'b0;
                for (int i = 0; i < BIN_COUNT; i++) begin
                    r_counts[i] <= '0;
                end
            end
        end
    end

    // gap measurement and bin search
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.take_gap) begin
            r_gap <= r_in.timestamp_ms - r_prev;
        end
        if (i_cmd.scale) begin
            r_big    <= (r_gap[TS_W-1:GAP_NARROW_W] != '0);
            r_scaled <= SCALED_W'(r_gap[GAP_NARROW_W-1:0]) * SCALED_W'(NS_PER_MS);
        end
        if (i_cmd.mul) begin
            r_rhs <= RHS_W'(cur_limit) * RHS_W'(r_period);
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + LIMIT_IDX_W'(1);
        end
        if (i_cmd.bin_hit) begin
            r_bin <= IDX_W'(r_k);
        end else if (i_cmd.bin_last) begin
            r_bin <= LAST_BIN;
        end
        if (i_cmd.start_report) begin
            r_length <= r_in.timestamp_ms - r_start;
            r_idx    <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.session_start_out <= r_start;
            r_out.session_length_ms <= r_length;
            r_out.bin_index         <= BIN_IDX_W'(r_idx);
            r_out.bin_count         <= BIN_CNT_W'(rd_count);
            r_out.last              <= (r_idx == LAST_BIN);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("held result overwritten");

    a_cleared_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_idx == LAST_BIN) |=> (!r_pending && !r_open))
        else $error("session not cleared after report");

    a_count_only_long_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_bin |-> (r_big || r_scaled > thr))
        else $error("short gap counted");

endmodule

>>> rtl/core/frame_gap_jank_histogram_core.sv
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_stall   o_out_item (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item at a time; an ignored, opening or backward frame sees only the frame state, a
// short gap also scale and threshold, a counted gap then a multiply and compare per limit
// tried on one shared 8x30 multiply and last the bin increment; a report emits each bin,
// waiting while the result side stalls, or with nothing counted only closes the session
// the next item is taken while the last result still sits in the output register
// synchronous active-low reset returns both registers to their defaults, clears
// the histogram and the session; config writes are always taken
module frame_gap_jank_histogram_core
    import fgjh_pkg::*;
#(
    parameter int BIN_COUNT   = 9,
    parameter int COUNT_WIDTH = 32
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMITS_W-1:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    assign o_cfg_ready = 1'b1;

    fgjh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fgjh_dp #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> dv/jank_histogram_checker.sv
module jank_histogram_checker
    import fgjh_pkg::*;
#(
    parameter int BIN_COUNT   = 9,
    parameter int COUNT_WIDTH = 32
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMITS_W-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMITS_USED = (BIN_COUNT - 1 < LIMIT_NUM) ? BIN_COUNT - 1 : LIMIT_NUM;
    localparam int MAX_LINES   = 40;

    logic [PERIOD_W-1:0]    period_ns;
    logic [LIMITS_W-1:0]    limits;
    logic                   sess_open;
    logic [TS_W-1:0]        sess_start;
    logic [TS_W-1:0]        prev_frame;
    logic [COUNT_WIDTH-1:0] hist [BIN_COUNT];
    logic                   hist_dirty;
    t_out_item              owed_bins [$];
    int                     fails = 0;

    assign o_fail_count = fails;

    task automatic log_mismatch(input string msg);
        fails++;
        if (fails <= MAX_LINES) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic clear_session();
        sess_open  = 1'b0;
        sess_start = '0;
        hist_dirty = 1'b0;
        foreach (hist[i]) hist[i] = '0;
    endtask

    // first limit whose frame count times the period exceeds the scaled gap
    function automatic int gap_bin(input logic [63:0] scaled);
        logic [63:0] bound;
        for (int k = 0; k < LIMITS_USED; k++) begin
            bound = 64'(limits[k*LIMIT_W +: LIMIT_W]) * 64'(period_ns);
            if (scaled < bound) begin
                return k;
            end
        end
        return BIN_COUNT - 1;
    endfunction

    task automatic histogram_step(input t_in_item it);
        logic [TS_W-1:0] gap;
        logic [63:0]     scaled;
        int              bin;
        t_out_item       r;
        if (it.action == ACT_FRAME) begin
            if (!it.scrolling) begin
                return;
            end
            if (!sess_open) begin
                sess_open  = 1'b1;
                sess_start = it.timestamp_ms;
                prev_frame = it.timestamp_ms;
                return;
            end
            // time going backward counts no gap
            if (it.timestamp_ms < prev_frame) begin
                prev_frame = it.timestamp_ms;
                return;
            end
            gap        = it.timestamp_ms - prev_frame;
            prev_frame = it.timestamp_ms;
            scaled     = 64'(gap) * 64'(NS_PER_MS);
            if (scaled <= 64'(period_ns) * 64'd2) begin
                return;
            end
            bin = gap_bin(scaled);
            if (hist[bin] != '1) begin
                hist[bin] = hist[bin] + COUNT_WIDTH'(1);
            end
            hist_dirty = 1'b1;
        end else if (!hist_dirty) begin
            // nothing counted: the report only closes the session
            sess_open  = 1'b0;
            sess_start = '0;
        end else begin
            for (int i = 0; i < BIN_COUNT; i++) begin
                r.session_start_out = sess_start;
                r.session_length_ms = it.timestamp_ms - sess_start;
                r.bin_index         = BIN_IDX_W'(i);
                r.bin_count         = BIN_CNT_W'(hist[i]);
                r.last              = (i == BIN_COUNT - 1);
                owed_bins.push_back(r);
            end
            clear_session();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            period_ns  = PERIOD_RESET;
            limits     = LIMITS_RESET;
            prev_frame = '0;
            clear_session();
            owed_bins.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_VSYNC_PERIOD: period_ns = i_cfg_data[PERIOD_W-1:0];
                    REG_BIN_LIMITS:   limits = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_bins.size() == 0) begin
                    log_mismatch($sformatf("result for bin %0d with none expected",
                                           i_out_item.bin_index));
                end else begin
                    want = owed_bins.pop_front();
                    check_field("session_start_out", 64'(i_out_item.session_start_out),
                                64'(want.session_start_out));
                    check_field("session_length_ms", 64'(i_out_item.session_length_ms),
                                64'(want.session_length_ms));
                    check_field("bin_index", 64'(i_out_item.bin_index),
                                64'(want.bin_index));
                    check_field("bin_count", 64'(i_out_item.bin_count),
                                64'(want.bin_count));
                    check_field("last", 64'(i_out_item.last), 64'(want.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                histogram_step(i_in_item);
            end
        end
        o_owed <= owed_bins.size();
    end

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fgjh_pkg::*;

    localparam int BINS          = 9;
    localparam int COUNT_BITS    = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PHASES        = 6;
    localparam logic [TS_W-1:0] TS_MAX = '1;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    t_in_item             in_item    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [LIMITS_W-1:0]  cfg_data   = '0;
    int                   fail_count;
    int                   owed;
    int                   hold_asked = 0;
    int                   quiet      = 0;
    logic                 calm       = 1'b0;
    logic [TS_W-1:0]      now_ms     = '0;
    logic [PERIOD_W-1:0]  cur_period = PERIOD_RESET;

    always #5 clk = ~clk;

    frame_gap_jank_histogram_core #(
        .BIN_COUNT   (BINS),
        .COUNT_WIDTH (COUNT_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jank_histogram_checker #(
        .BIN_COUNT   (BINS),
        .COUNT_WIDTH (COUNT_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_owed       (owed)
    );

    // watchdog on cycles with no item moving on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : result_side
        int hold_served;
        int span;
        int pick;
        hold_served = 0;
        @(posedge clk);
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_asked != hold_served) begin
                // long hold so the block backs up into its input
                hold_served = hold_asked;
                out_stall <= 1'b1;
                span = HOLD_CYCLES;
            end else if (pick < 45) begin
                out_stall <= 1'b0;
                span = $urandom_range(1, 6);
            end else if (pick < 80) begin
                out_stall <= 1'b1;
                span = $urandom_range(1, 3);
            end else if (pick < 88) begin
                out_stall <= 1'b1;
                span = $urandom_range(8, 40);
            end else begin
                out_stall <= 1'b0;
                span = $urandom_range(30, 120);
            end
            repeat (span) @(posedge clk);
        end
    end

    function automatic logic [TS_W-1:0] any_time();
        return TS_W'({$urandom, $urandom});
    endfunction

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 50) begin
            return 0;
        end
        if (pick < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input logic act, input logic [TS_W-1:0] ts, input logic scroll);
        int       gap;
        t_in_item it;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.action       = act;
        it.timestamp_ms = ts;
        it.scrolling    = scroll;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMITS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] period,
                              input logic [LIMITS_W-1:0] limits);
        write_reg(REG_VSYNC_PERIOD, LIMITS_W'(period));
        write_reg(REG_BIN_LIMITS, limits);
        cfg_valid <= 1'b0;
        cur_period = period;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (owed != 0);
        // a trailing frame may still be in flight without any result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // next frame time, mostly near the threshold or aimed at some bin
    function automatic logic [TS_W-1:0] next_frame_time();
        int          pick;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            span = 64'(cur_period) * 2 / 64'(NS_PER_MS) + $urandom_range(0, 1);
        end else if (pick < 75) begin
            span = 64'($urandom_range(0, 260)) * 64'(cur_period) / 64'(NS_PER_MS)
                   + $urandom_range(0, 1);
        end else if (pick < 85) begin
            span = $urandom_range(0, 3);
        end else if (pick < 94) begin
            now_ms = now_ms - TS_W'($urandom_range(1, 200));
            return now_ms;
        end else begin
            now_ms = any_time();
            return now_ms;
        end
        now_ms = now_ms + TS_W'(span);
        return now_ms;
    endfunction

    task automatic random_phase(input int quota);
        int              sent;
        int              frames;
        logic [TS_W-1:0] stamp;
        sent = 0;
        while (sent < quota) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                now_ms = any_time();
            end
            frames = $urandom_range(2, 12);
            repeat (frames) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(ACT_FRAME, any_time(), 1'b0);
                end else begin
                    send_item(ACT_FRAME, next_frame_time(), 1'b1);
                    sent++;
                end
            end
            stamp = ($urandom_range(0, 9) == 0) ? any_time()
                                                : now_ms + TS_W'($urandom_range(0, 40));
            now_ms = stamp;
            send_item(ACT_REPORT, stamp, $urandom_range(0, 4) != 0);
            sent++;
            if ($urandom_range(0, 7) == 0) begin
                send_item(ACT_REPORT, now_ms, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] phase_period [PHASES];
        logic [LIMITS_W-1:0] phase_limits [PHASES];
        int                  phase_items  [PHASES];
        phase_period[0] = PERIOD_RESET;
        phase_limits[0] = LIMITS_RESET;
        phase_items[0]  = 40;
        phase_period[1] = PERIOD_W'(1);
        phase_limits[1] = '1;
        phase_items[1]  = 25;
        phase_period[2] = PERIOD_W'(1_000_000_000);
        phase_limits[2] = 64'h0F0C_0A08_0605_0403;
        phase_items[2]  = 35;
        // gap of one ms lands exactly on the threshold here
        phase_period[3] = PERIOD_W'(500_000);
        phase_limits[3] = {$urandom, $urandom};
        phase_items[3]  = 35;
        phase_period[4] = PERIOD_W'($urandom_range(1_000_000, 50_000_000));
        phase_limits[4] = '0;
        phase_items[4]  = 25;
        phase_period[5] = PERIOD_W'($urandom_range(1_000_000, 50_000_000));
        phase_limits[5] = {$urandom, $urandom};
        phase_items[5]  = 35;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ignored frame, then a report with nothing counted
        send_item(ACT_FRAME, TS_MAX, 1'b0);
        send_item(ACT_REPORT, '0, 1'b0);
        // session opening at time zero, zero gap, low bins, backward time, top bin
        send_item(ACT_FRAME, TS_W'(0), 1'b1);
        send_item(ACT_FRAME, TS_W'(0), 1'b1);
        send_item(ACT_FRAME, TS_W'(34), 1'b1);
        send_item(ACT_FRAME, TS_W'(134), 1'b1);
        send_item(ACT_FRAME, TS_W'(235), 1'b1);
        send_item(ACT_FRAME, TS_W'(200), 1'b1);
        send_item(ACT_FRAME, TS_W'(3201), 1'b1);
        send_item(ACT_REPORT, TS_MAX, 1'b0);
        send_item(ACT_REPORT, TS_W'(5), 1'b1);
        // session length wraps past the top of the time range
        send_item(ACT_FRAME, TS_MAX - TS_W'(5000), 1'b1);
        send_item(ACT_FRAME, TS_MAX, 1'b1);
        send_item(ACT_REPORT, TS_W'(10), 1'b1);
        // short gaps only, so the report just closes the session, then a new session with a counted gap
        send_item(ACT_FRAME, TS_W'(1000), 1'b1);
        send_item(ACT_FRAME, TS_W'(1020), 1'b1);
        send_item(ACT_REPORT, TS_W'(1030), 1'b1);
        send_item(ACT_FRAME, TS_W'(1040), 1'b1);
        send_item(ACT_FRAME, TS_W'(1074), 1'b1);
        send_item(ACT_REPORT, TS_W'(1100), 1'b1);
        drain();

        // zero period puts every positive gap in the last bin
        set_config('0, LIMITS_RESET);
        send_item(ACT_FRAME, TS_W'(100), 1'b1);
        send_item(ACT_FRAME, TS_W'(101), 1'b1);
        send_item(ACT_FRAME, TS_W'(101), 1'b1);
        send_item(ACT_REPORT, TS_W'(200), 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_period[p], phase_limits[p]);
            if (p == 0) begin
                hold_asked <= hold_asked + 1;
                now_ms = TS_W'($urandom);
                send_item(ACT_FRAME, now_ms, 1'b1);
                send_item(ACT_FRAME, now_ms + TS_W'(60), 1'b1);
                send_item(ACT_REPORT, now_ms + TS_W'(70), 1'b1);
                now_ms = now_ms + TS_W'(70);
            end
            random_phase(phase_items[p]);
            drain();
        end

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fgjh_pkg.sv
rtl/core/fgjh_ctrl.sv
rtl/core/fgjh_dp.sv
rtl/core/frame_gap_jank_histogram_core.sv
dv/jank_histogram_checker.sv
dv/tb.sv
